// ===== design/acss_pkg.sv =====
// shared types and constants for the adc channel scan sequencer
`default_nettype none

package acss_pkg;

    localparam int CH_W   = 4;
    localparam int SMP_W  = 12;
    localparam int CMD_W  = 16;

    localparam logic [CMD_W-1:0] CMD_BASE  = 16'h1000;
    localparam int               CMD_SHIFT = 7;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    localparam logic KIND_CMD = 1'b0;
    localparam logic KIND_SMP = 1'b1;

    typedef struct packed {
        logic             load;
        logic             kind;
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
        logic             last;
    } emit_t;

endpackage

`default_nettype wire

// ===== design/acss_store.sv =====
// per-channel sample memory with registered read
`default_nettype none

module acss_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [acss_pkg::SMP_W-1:0] wdata,
    input  wire logic                     re,
    input  wire logic [AW-1:0]            raddr,
    output logic [acss_pkg::SMP_W-1:0]    rdata
);
    import acss_pkg::*;

    logic [SMP_W-1:0] mem [DEPTH];
    logic [SMP_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/acss_seq.sv =====
// scan sequencer: seen mask, pointer search and sample dump over one stepping counter
`default_nettype none

module acss_seq #(
    parameter int CHANNEL_COUNT = 16,
    parameter int IDX_W         = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       mode,
    input  wire logic                       transfer_ok,
    input  wire logic [acss_pkg::CH_W-1:0]  frame_channel,
    input  wire logic [acss_pkg::SMP_W-1:0] frame_sample,
    input  wire logic                       out_free,
    output acss_pkg::emit_t                 emit,
    output logic                            st_we,
    output logic [IDX_W-1:0]                st_waddr,
    output logic [acss_pkg::SMP_W-1:0]      st_wdata,
    output logic                            st_re,
    output logic [IDX_W-1:0]                st_raddr,
    input  wire logic [acss_pkg::SMP_W-1:0] st_rdata
);
    import acss_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CHECK    = 6'b000010,
        S_SEARCH   = 6'b000100,
        S_EMIT_CMD = 6'b001000,
        S_READ     = 6'b010000,
        S_EMIT_SMP = 6'b100000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNEL_COUNT - 1);
    localparam logic [CH_W:0]    CNT_L    = (CH_W + 1)'(CHANNEL_COUNT);

    state_t                   state_reg, state_next;
    logic [CHANNEL_COUNT-1:0] seen_mask_reg, seen_mask_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic [IDX_W-1:0]         cand_reg, cand_next;
    logic                     scanning_reg, scanning_next;

    logic             accept;
    logic             ch_in_range;
    logic [IDX_W-1:0] ch_idx;
    logic [IDX_W-1:0] cand_inc;
    logic             record;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign ch_in_range = ({1'b0, frame_channel} < CNT_L);
    assign ch_idx      = frame_channel[IDX_W-1:0];
    assign cand_inc    = (cand_reg == LAST_IDX) ? '0 : cand_reg + 1'b1;
    assign record      = accept && (mode == MODE_FRAME) && scanning_reg && transfer_ok
                         && ch_in_range && !seen_mask_reg[ch_idx];

    assign st_we    = record;
    assign st_waddr = ch_idx;
    assign st_wdata = frame_sample;
    assign st_re    = (state_reg == S_READ);
    assign st_raddr = cand_reg;

    always_comb
    begin
        state_next     = state_reg;
        seen_mask_next = seen_mask_reg;
        ptr_next       = ptr_reg;
        cand_next      = cand_reg;
        scanning_next  = scanning_reg;
        emit           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_START)
                    begin
                        seen_mask_next = '0;
                        ptr_next       = '0;
                        scanning_next  = 1'b1;
                        state_next     = S_EMIT_CMD;
                    end
                    else if (scanning_reg)
                    begin
                        if (record)
                        begin
                            seen_mask_next[ch_idx] = 1'b1;
                        end
                        cand_next  = ptr_reg;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (&seen_mask_reg)
                begin
                    cand_next  = '0;
                    state_next = S_READ;
                end
                else
                begin
                    cand_next  = cand_inc;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!seen_mask_reg[cand_reg])
                begin
                    ptr_next   = cand_reg;
                    state_next = S_EMIT_CMD;
                end
                else
                begin
                    cand_next = cand_inc;
                end
            end
            S_EMIT_CMD:
            begin
                if (out_free)
                begin
                    emit.load    = 1'b1;
                    emit.kind    = KIND_CMD;
                    emit.channel = CH_W'(ptr_reg);
                    state_next   = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT_SMP;
            end
            S_EMIT_SMP:
            begin
                if (out_free)
                begin
                    emit.load    = 1'b1;
                    emit.kind    = KIND_SMP;
                    emit.channel = CH_W'(cand_reg);
                    emit.sample  = st_rdata;
                    emit.last    = (cand_reg == LAST_IDX);
                    if (cand_reg == LAST_IDX)
                    begin
                        scanning_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cand_next  = cand_inc;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_mask_reg <= '0;
            ptr_reg       <= '0;
            cand_reg      <= '0;
            scanning_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_mask_reg <= seen_mask_next;
            ptr_reg       <= ptr_next;
            cand_reg      <= cand_next;
            scanning_reg  <= scanning_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/adc_channel_scan_sequencer.sv =====
// top level of the adc channel scan sequencer: sequencer, sample memory, output register
// One scan of a manual-mode SPI ADC. A start beat (mode 0) clears the seen channels and
// yields the command beat for channel 0 via the command state and the output register. A
// frame beat (mode 1) searches for the next unseen channel by walking a single pointer
// incrementer one channel per cycle. The frame that completes the scan instead yields
// CHANNEL_COUNT sample beats, each paced by the registered read of the sample memory and
// held while the output is full; the final one has last set. Frames outside a scan
// give no beat. The input is not ready while a beat is being worked on; one output
// register holds the pending result so a new input beat can be taken while it waits.
`default_nettype none

module adc_channel_scan_sequencer #(
    parameter int CHANNEL_COUNT = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       mode,
    input  wire logic                       transfer_ok,
    input  wire logic [acss_pkg::CH_W-1:0]  frame_channel,
    input  wire logic [acss_pkg::SMP_W-1:0] frame_sample,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            kind,
    output logic [acss_pkg::CMD_W-1:0]      command_word,
    output logic [acss_pkg::CH_W-1:0]       channel,
    output logic [acss_pkg::SMP_W-1:0]      sample,
    output logic                            last
);
    import acss_pkg::*;

    localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    emit_t            emit;
    logic             out_free;
    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    logic [SMP_W-1:0] st_wdata;
    logic             st_re;
    logic [IDX_W-1:0] st_raddr;
    logic [SMP_W-1:0] st_rdata;

    logic             out_valid_reg;
    logic             kind_reg;
    logic [CMD_W-1:0] command_word_reg;
    logic [CH_W-1:0]  channel_reg;
    logic [SMP_W-1:0] sample_reg;
    logic             last_reg;

    assign out_free = !out_valid_reg || out_ready;

    acss_seq #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .IDX_W         (IDX_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .transfer_ok   (transfer_ok),
        .frame_channel (frame_channel),
        .frame_sample  (frame_sample),
        .out_free      (out_free),
        .emit          (emit),
        .st_we         (st_we),
        .st_waddr      (st_waddr),
        .st_wdata      (st_wdata),
        .st_re         (st_re),
        .st_raddr      (st_raddr),
        .st_rdata      (st_rdata)
    );

    acss_store #(
        .DEPTH (CHANNEL_COUNT),
        .AW    (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            kind_reg    <= emit.kind;
            channel_reg <= emit.channel;
            sample_reg  <= emit.sample;
            last_reg    <= emit.last;
            if (emit.kind == KIND_CMD)
            begin
                command_word_reg <= CMD_BASE | (CMD_W'(emit.channel) << CMD_SHIFT);
            end
            else
            begin
                command_word_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign command_word = command_word_reg;
    assign channel      = channel_reg;
    assign sample       = sample_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the adc channel scan sequencer with random scans and stalls
`timescale 1ns / 1ps

module testbench;

    import acss_pkg::*;

    localparam int CH_CNT       = 16;
    localparam int RANDOM_ITEMS = 100;
    localparam int CALM_TAIL    = 30;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT        = 200000;

    typedef struct packed {
        logic             mode;
        logic             transfer_ok;
        logic [CH_W-1:0]  frame_channel;
        logic [SMP_W-1:0] frame_sample;
    } frame_item_t;

    typedef struct packed {
        logic             kind;
        logic [CMD_W-1:0] command_word;
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
        logic             last;
    } scan_result_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             mode = 1'b0;
    logic             transfer_ok = 1'b0;
    logic [CH_W-1:0]  frame_channel = '0;
    logic [SMP_W-1:0] frame_sample = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             kind;
    logic [CMD_W-1:0] command_word;
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
    logic             last;

    frame_item_t      pending_frames[$];
    scan_result_t     expected_beats[$];

    logic [CH_CNT-1:0] seen_channels;
    int                scan_pointer;
    logic              scan_active;
    logic [SMP_W-1:0]  stored_samples[CH_CNT];

    int   errors = 0;
    int   cycles = 0;
    int   beats_in = 0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   hold_count = 0;
    logic long_hold = 1'b0;
    logic hold_done = 1'b0;
    logic idle_ok;

    adc_channel_scan_sequencer #(.CHANNEL_COUNT(CH_CNT)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .transfer_ok   (transfer_ok),
        .frame_channel (frame_channel),
        .frame_sample  (frame_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .command_word  (command_word),
        .channel       (channel),
        .sample        (sample),
        .last          (last)
    );

    assign idle_ok = pending_frames.size() > CALM_TAIL;

    function automatic scan_result_t command_for(int ch);
        scan_result_t r;
        r = '0;
        r.kind = KIND_CMD;
        r.command_word = CMD_BASE;
        r.command_word[CMD_SHIFT +: CH_W] = CH_W'(ch);
        r.channel = CH_W'(ch);
        return r;
    endfunction

    function automatic void predict_scan_beats(frame_item_t it);
        scan_result_t r;
        int cand;
        logic found;
        if (it.mode == MODE_START) begin
            seen_channels = '0;
            scan_pointer = 0;
            scan_active = 1'b1;
            expected_beats.push_back(command_for(0));
        end else if (scan_active) begin
            if (it.transfer_ok && it.frame_channel < CH_CNT && !seen_channels[it.frame_channel])
            begin
                seen_channels[it.frame_channel] = 1'b1;
                stored_samples[it.frame_channel] = it.frame_sample;
            end
            if (seen_channels == '1) begin
                for (int i = 0; i < CH_CNT; i++) begin
                    r = '0;
                    r.kind = KIND_SMP;
                    r.channel = CH_W'(i);
                    r.sample = stored_samples[i];
                    r.last = (i == CH_CNT - 1);
                    expected_beats.push_back(r);
                end
                scan_active = 1'b0;
            end else begin
                found = 1'b0;
                for (int i = 1; i <= CH_CNT; i++) begin
                    cand = (scan_pointer + i) % CH_CNT;
                    if (!found && !seen_channels[cand]) begin
                        scan_pointer = cand;
                        found = 1'b1;
                    end
                end
                expected_beats.push_back(command_for(scan_pointer));
            end
        end
    endfunction

    function automatic void add_frame(logic m, logic ok, logic [CH_W-1:0] ch,
                                      logic [SMP_W-1:0] smp);
        frame_item_t it;
        it.mode = m;
        it.transfer_ok = ok;
        it.frame_channel = ch;
        it.frame_sample = smp;
        pending_frames.push_back(it);
    endfunction

    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $error("%s expected %0h actual %0h", name, exp, act);
            errors++;
        end
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        int perm[CH_CNT];
        int counted;
        int stop_at;
        int j;
        int tmp;

        seen_channels = '0;
        scan_pointer = 0;
        scan_active = 1'b0;
        foreach (stored_samples[i]) stored_samples[i] = '0;

        // directed: ignored frame, start with junk, failed, repeat, restart, full scan
        add_frame(MODE_FRAME, 1'b1, 4'd5, 12'hfff);
        add_frame(MODE_START, 1'b1, 4'hf, 12'hfff);
        add_frame(MODE_FRAME, 1'b1, 4'd0, 12'h000);
        add_frame(MODE_FRAME, 1'b1, 4'hf, 12'hfff);
        add_frame(MODE_FRAME, 1'b0, 4'd3, 12'habc);
        add_frame(MODE_FRAME, 1'b1, 4'd0, 12'h555);
        add_frame(MODE_START, 1'b0, 4'd0, 12'h000);
        for (int i = CH_CNT - 1; i >= 0; i--)
            add_frame(MODE_FRAME, 1'b1, CH_W'(i),
                      (i == CH_CNT - 1) ? 12'hfff : (i == 0) ? 12'h000 :
                      (i % 2) ? 12'haaa : 12'h555);
        add_frame(MODE_FRAME, 1'b1, 4'd7, 12'h123);

        // random scans with failures, repeats, aborted scans and noise
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                add_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          CH_W'($urandom_range(0, CH_CNT - 1)),
                          SMP_W'($urandom_range(0, 4095)));
            end else begin
                add_frame(MODE_START, 1'($urandom_range(0, 1)),
                          CH_W'($urandom_range(0, CH_CNT - 1)),
                          SMP_W'($urandom_range(0, 4095)));
                counted++;
                for (int i = 0; i < CH_CNT; i++) perm[i] = i;
                for (int i = CH_CNT - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, CH_CNT - 1) : CH_CNT;
                for (int k = 0; k < stop_at; k++) begin
                    while ($urandom_range(0, 5) == 0) begin
                        if ($urandom_range(0, 1))
                            add_frame(MODE_FRAME, 1'b0, CH_W'($urandom_range(0, CH_CNT - 1)),
                                      SMP_W'($urandom_range(0, 4095)));
                        else
                            add_frame(MODE_FRAME, 1'b1, CH_W'(perm[$urandom_range(0, k)]),
                                      SMP_W'($urandom_range(0, 4095)));
                        counted++;
                    end
                    add_frame(MODE_FRAME, 1'b1, CH_W'(perm[k]),
                              SMP_W'($urandom_range(0, 4095)));
                    counted++;
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_frames.size() > 0 || in_valid) @(posedge clk);
        while (expected_beats.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_beats.size() > 0) begin
            $error("%0d expected result beats never arrived", expected_beats.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS adc_channel_scan_sequencer");
        else
            $display("FAIL adc_channel_scan_sequencer");
        $finish;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("FAIL adc_channel_scan_sequencer");
            $finish;
        end
    end

    // sender
    always @(posedge clk or negedge rst_n) begin
        frame_item_t it;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                it.mode = mode;
                it.transfer_ok = transfer_ok;
                it.frame_channel = frame_channel;
                it.frame_sample = frame_sample;
                predict_scan_beats(it);
                beats_in++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (idle_ok && $urandom_range(0, 5) == 0) begin
                    in_gap <= $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    it = pending_frames.pop_front();
                    mode <= it.mode;
                    transfer_ok <= it.transfer_ok;
                    frame_channel <= it.frame_channel;
                    frame_sample <= it.frame_sample;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold so the block backs up into its input
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            long_hold <= 1'b0;
            hold_done <= 1'b0;
            hold_count <= 0;
        end else if (!hold_done && !long_hold && beats_in >= HOLD_AT) begin
            long_hold <= 1'b1;
            hold_count <= 0;
        end else if (long_hold) begin
            if (hold_count == HOLD_CYCLES) begin
                long_hold <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                hold_count <= hold_count + 1;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end else if (long_hold) begin
            out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_ready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            out_gap <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk) begin
        scan_result_t exp;
        if (rst_n && out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat kind %0d channel %0d", kind, channel);
                errors++;
            end else begin
                exp = expected_beats.pop_front();
                check_field("kind", exp.kind, kind);
                check_field("command_word", exp.command_word, command_word);
                check_field("channel", exp.channel, channel);
                check_field("sample", exp.sample, sample);
                check_field("last", exp.last, last);
            end
        end
    end

endmodule
